>>> src/mst_pkg.sv
// Shared types and constants for the Kruskal spanning tree block.
package mst_pkg;
   localparam int MAX_EDGES_DEF = 64;
   localparam int MAX_NODES_DEF = 64;
   localparam int NODE_W = 6;
   localparam int WGT_W = 16;
   localparam int SUM_W = 22;
   localparam int EDGE_W = 28;

   typedef struct packed {
      logic signed [WGT_W-1:0] w;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
   } edge_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SRD, ST_SKEY, ST_SCMP, ST_SWR, ST_CLR, ST_ERD, ST_EGET,
      ST_WALK, ST_JOIN, ST_EMIT
   } state_type;

   function automatic logic edge_less(edge_type x, edge_type y);
      if (x.w != y.w) return x.w < y.w;
      if (x.a != y.a) return x.a < y.a;
      return x.b < y.b;
   endfunction
endpackage

>>> src/mst_roots.sv
// Union-find root table: identity clear, parent reads and linking.
module mst_roots (
   input  logic clock,
   input  logic clr_en,
   input  logic [mst_pkg::NODE_W-1:0] clr_addr,
   input  logic wr_en,
   input  logic [mst_pkg::NODE_W-1:0] wr_addr,
   input  logic [mst_pkg::NODE_W-1:0] wr_data,
   input  logic [mst_pkg::NODE_W-1:0] rd_addr,
   output logic [mst_pkg::NODE_W-1:0] rd_data
);
   logic [mst_pkg::NODE_W-1:0] mem [0:(1<<mst_pkg::NODE_W)-1];

   always_ff @(posedge clock) begin
      if (clr_en) mem[clr_addr] <= clr_addr;
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> src/minimum_spanning_tree_kruskal_top.sv
// Top level of the Kruskal minimum spanning tree block.
//
//  channel | dir | payload
//  req_*   | in  | tdata {edge_weight,node_b,node_a}, tlast = last_edge
//  rsp_*   | out | tdata {overflow,tree_weight,in_tree,out_weight,out_node_b,out_node_a}
//                  tlast = last_result
//
// Loading accepts one edge per cycle. After the last edge an insertion sort
// over the edge memory reads each edge, latches it as the key, shifts larger
// neighbors up one slot (O(n^2) shifts) and writes the key back; an identity
// clear of all 64 root table entries follows, then each edge is fetched, takes
// two bounded root walks on the registered root table read port, is linked and emitted.
// Reset is synchronous; req_tready is low during a run and the sequencer holds
// while a result waits on rsp_tready.
module minimum_spanning_tree_kruskal_top #(
   parameter int MAX_EDGES = mst_pkg::MAX_EDGES_DEF,
   parameter int MAX_NODES = mst_pkg::MAX_NODES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,   // node_a[5:0], node_b[11:6], edge_weight[27:12]
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata,   // out_node_a, out_node_b, out_weight, in_tree,
                                    // tree_weight, overflow (low to high)
   output logic rsp_tlast
);
   localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int SW = $clog2(MAX_NODES + 1);
   localparam int NW = mst_pkg::NODE_W;

   mst_pkg::edge_type store [0:MAX_EDGES-1];
   mst_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic drop_ff, drop_in;
   mst_pkg::edge_type key_ff, key_in, rd_ff, cur_ff, cur_in;
   logic [NW-1:0] clr_ff, clr_in, node_ff, node_in, ra_ff, ra_in;
   logic [SW-1:0] step_ff, step_in;
   logic side_ff, side_in;
   logic signed [mst_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic jn_ff, jn_in;
   logic [IW-1:0] raddr, waddr;
   logic we;
   mst_pkg::edge_type wdata;
   logic [NW-1:0] par;
   logic accept, rwe;
   mst_pkg::edge_type in_e;

   assign accept = req_tvalid && req_tready;
   assign in_e.a = req_tdata[5:0];
   assign in_e.b = req_tdata[11:6];
   assign in_e.w = req_tdata[27:12];

   // edge memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) store[waddr] <= wdata;
      rd_ff <= store[raddr];
   end

   // root table read address follows the next walk node, so par matches node_ff
   mst_roots u_roots (
      .clock(clock), .clr_en(state_ff == mst_pkg::ST_CLR), .clr_addr(clr_ff),
      .wr_en(rwe), .wr_addr(ra_ff), .wr_data(node_ff),
      .rd_addr(node_in), .rd_data(par)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mst_pkg::ST_LOAD;
         cnt_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         drop_ff <= drop_in;
      end
      i_ff <= i_in; j_ff <= j_in; key_ff <= key_in; cur_ff <= cur_in;
      clr_ff <= clr_in; node_ff <= node_in; ra_ff <= ra_in; step_ff <= step_in;
      side_ff <= side_in; sum_ff <= sum_in; jn_ff <= jn_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mst_pkg::ST_LOAD:
            if (accept && req_tlast)
               state_in = (cnt_ff == CW'(0) && cnt_ff != CW'(MAX_EDGES)) ?
                          mst_pkg::ST_CLR : mst_pkg::ST_SRD;
         mst_pkg::ST_SRD:
            state_in = (i_ff >= cnt_ff) ? mst_pkg::ST_CLR : mst_pkg::ST_SKEY;
         mst_pkg::ST_SKEY: state_in = mst_pkg::ST_SCMP;
         mst_pkg::ST_SCMP:
            state_in = (j_ff != '0 && mst_pkg::edge_less(key_ff, rd_ff)) ?
                       mst_pkg::ST_SCMP : mst_pkg::ST_SWR;
         mst_pkg::ST_SWR: state_in = mst_pkg::ST_SRD;
         mst_pkg::ST_CLR:
            if (clr_ff == '1) state_in = mst_pkg::ST_ERD;
         mst_pkg::ST_ERD: state_in = mst_pkg::ST_EGET;
         mst_pkg::ST_EGET: state_in = mst_pkg::ST_WALK;
         mst_pkg::ST_WALK:
            if ((par == node_ff || step_ff == SW'(MAX_NODES)) && side_ff)
               state_in = mst_pkg::ST_JOIN;
         mst_pkg::ST_JOIN: state_in = mst_pkg::ST_EMIT;
         mst_pkg::ST_EMIT:
            if (rsp_tready)
               state_in = (i_ff + CW'(1) >= cnt_ff) ? mst_pkg::ST_LOAD : mst_pkg::ST_ERD;
         default: state_in = mst_pkg::ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in = cnt_ff; drop_in = drop_ff; i_in = i_ff; j_in = j_ff;
      key_in = key_ff; cur_in = cur_ff; clr_in = clr_ff; node_in = node_ff;
      ra_in = ra_ff; step_in = step_ff; side_in = side_ff; sum_in = sum_ff;
      jn_in = jn_ff;
      we = 1'b0; waddr = '0; wdata = key_ff; raddr = '0; rwe = 1'b0;
      req_tready = (state_ff == mst_pkg::ST_LOAD);
      rsp_tvalid = (state_ff == mst_pkg::ST_EMIT);
      unique case (state_ff)
         mst_pkg::ST_LOAD: begin
            if (accept) begin
               if (cnt_ff < CW'(MAX_EDGES)) begin
                  we = 1'b1; waddr = cnt_ff[IW-1:0]; wdata = in_e;
                  cnt_in = cnt_ff + CW'(1);
               end else drop_in = 1'b1;
            end
            i_in = CW'(1); clr_in = '0; sum_in = '0;
         end
         mst_pkg::ST_SRD: begin
            // fetch key at i
            raddr = i_ff[IW-1:0];
            j_in = i_ff;
         end
         mst_pkg::ST_SKEY: begin
            // latch key, fetch its left neighbor
            key_in = rd_ff;
            raddr = IW'(j_ff - CW'(1));
         end
         mst_pkg::ST_SCMP: begin
            // shift the larger neighbor up one slot and fetch the next one
            if (j_ff != '0 && mst_pkg::edge_less(key_ff, rd_ff)) begin
               we = 1'b1; waddr = j_ff[IW-1:0]; wdata = rd_ff;
               j_in = j_ff - CW'(1);
               raddr = IW'(j_ff - CW'(2));
            end
         end
         mst_pkg::ST_SWR: begin
            we = 1'b1; waddr = j_ff[IW-1:0]; wdata = key_ff;
            i_in = i_ff + CW'(1);
         end
         mst_pkg::ST_CLR: begin
            clr_in = clr_ff + NW'(1); i_in = '0;
         end
         mst_pkg::ST_ERD: raddr = i_ff[IW-1:0];
         mst_pkg::ST_EGET: begin
            cur_in = rd_ff; node_in = rd_ff.a; step_in = '0; side_in = 1'b0;
         end
         mst_pkg::ST_WALK: begin
            if (par == node_ff || step_ff == SW'(MAX_NODES)) begin
               if (!side_ff) begin
                  ra_in = node_ff; node_in = cur_ff.b; step_in = '0; side_in = 1'b1;
               end
            end else begin
               node_in = par; step_in = step_ff + SW'(1);
            end
         end
         mst_pkg::ST_JOIN: begin
            jn_in = (ra_ff != node_ff);
            rwe = jn_in;
            if (jn_in) sum_in = sum_ff + mst_pkg::SUM_W'(cur_ff.w);
         end
         mst_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               i_in = i_ff + CW'(1);
               if (i_ff + CW'(1) >= cnt_ff) begin
                  cnt_in = '0; drop_in = 1'b0; i_in = CW'(1); clr_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {4'd0, drop_ff, sum_ff, jn_ff, cur_ff.w, cur_ff.b, cur_ff.a};
   assign rsp_tlast = (i_ff + CW'(1) >= cnt_ff);
endmodule
